>>> rtl/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher.
package rc4_pkg;

    localparam int OP_W    = 2;
    localparam int BYTE_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_REKEY  = 2'd0;
    localparam logic [OP_W-1:0] OP_NEWMSG = 2'd1;
    localparam logic [OP_W-1:0] OP_DATA   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_KSA_RD,
        S_KSA_J,
        S_KSA_WI,
        S_KSA_WJ,
        S_DAT_J,
        S_DAT_SW,
        S_DAT_KS,
        S_EMIT
    } t_state;

endpackage

>>> rtl/rc4_stream_cipher.sv
// RC4 stream cipher: key schedule and keystream generator around one 256 x 8 state memory.
//
// Usage
//   Configuration channel (i_cfg_valid / o_cfg_ready, always ready): index 0..3 writes key
//   words 0..3 (key byte n in bits 8n upward), index 4 writes the key length (low six bits).
//   Other indexes are dropped. Write only while the block is idle.
//   Input channel (i_in_valid / o_in_ready): one transfer per item. op 0 rekeys and runs
//   the schedule, op 1 starts a new message (i and j cleared, permutation kept), op 2 is
//   a data byte, op 3 is dropped. Data bytes before the first rekey give no result.
//   Output channel (o_out_valid / i_out_ready): one transfer per data byte, data_in XOR
//   keystream, held in an output register.
// Timing
//   Data byte: after the transfer the block runs S_DAT_J, S_DAT_SW and S_DAT_KS, registers
//   the result and takes no item until back in S_IDLE; the steps follow the dependent reads
//   S[i], S[j], S[S[i]+S[j]] and the swap write-back through the single-write-port memory.
//   Rekey: identity fill of all 256 entries, then one schedule step per entry (S_KSA_RD to
//   S_KSA_WJ), after which o_in_ready returns. New message and dropped items keep it idle.
//   If the receiver stalls, a finished byte waits in the output register and the next
//   item is still accepted; a second result waits internally until the register empties.
// Reset
//   Synchronous, active low: indices cleared, block unkeyed, key words zero, key length 1.
//   The permutation memory is not cleared; the first rekey fills it.
module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rc4_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // input item channel
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [rc4_pkg::OP_W-1:0]          i_op,
    input  logic [rc4_pkg::BYTE_W-1:0]        i_data_in,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]        o_data_out
);
    import rc4_pkg::*;

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_W  = MAX_KEY_BYTES * BYTE_W;
    localparam logic [5:0] MAX_LEN = 6'(MAX_KEY_BYTES);
    localparam logic [KIDX_W-1:0] KIDX_LAST = KIDX_W'(MAX_KEY_BYTES - 1);

    // permutation memory, one write and one registered read per cycle
    logic [BYTE_W-1:0] mem [256];
    logic [BYTE_W-1:0] r_rdata;
    logic              mem_we;
    logic [BYTE_W-1:0] mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_raddr;

    // configuration
    logic [KEY_W-1:0]  r_key;
    logic [5:0]        r_key_length;
    logic              cfg_we;

    // control and datapath
    t_state            r_state,     n_state;
    logic              r_keyed,     n_keyed;
    logic [BYTE_W-1:0] r_i,         n_i;
    logic [BYTE_W-1:0] r_j,         n_j;
    logic [BYTE_W-1:0] r_n,         n_n;
    logic [KIDX_W-1:0] r_kidx,      n_kidx;
    logic [KIDX_W-1:0] r_klen_last, n_klen_last;
    logic [BYTE_W-1:0] r_si,        n_si;
    logic [BYTE_W-1:0] r_sj,        n_sj;
    logic [BYTE_W-1:0] r_t,         n_t;
    logic [BYTE_W-1:0] r_din,       n_din;
    logic [BYTE_W-1:0] r_res,       n_res;
    logic              r_out_valid, n_out_valid;
    logic [BYTE_W-1:0] r_data_out,  n_data_out;

    logic [KIDX_W-1:0] klen_eff_m1;
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] ks;
    logic              slot_free;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_data_out;

    // ---------------------------------------------------------------- memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[mem_raddr];
    end

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key        <= '0;
            r_key_length <= 6'd1;
        end else if (cfg_we) begin
            for (int k = 0; k < MAX_KEY_BYTES; k++) begin
                if (i_cfg_index == CFG_IDX_W'(k >> 3)) begin
                    r_key[k*BYTE_W +: BYTE_W] <= i_cfg_data[(k & 7)*BYTE_W +: BYTE_W];
                end
            end
            if (i_cfg_index == CFG_KEY_LENGTH) begin
                r_key_length <= i_cfg_data[5:0];
            end
        end
    end

    // zero length counts as one, lengths above the key store saturate
    always_comb begin
        if (r_key_length == 6'd0) begin
            klen_eff_m1 = '0;
        end else if (r_key_length > MAX_LEN) begin
            klen_eff_m1 = KIDX_LAST;
        end else begin
            klen_eff_m1 = KIDX_W'(r_key_length - 6'd1);
        end
    end

    assign key_byte  = r_key[{r_kidx, 3'b000} +: BYTE_W];
    assign slot_free = !r_out_valid || i_out_ready;

    // keystream byte after the swap: forward the two freshly written entries
    always_comb begin
        if (r_t == r_j) begin
            ks = r_si;
        end else if (r_t == r_i) begin
            ks = r_sj;
        end else begin
            ks = r_rdata;
        end
    end

    // ---------------------------------------------------------------- state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_keyed     <= 1'b0;
            r_i         <= '0;
            r_j         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_keyed     <= n_keyed;
            r_i         <= n_i;
            r_j         <= n_j;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_kidx      <= n_kidx;
        r_klen_last <= n_klen_last;
        r_si        <= n_si;
        r_sj        <= n_sj;
        r_t         <= n_t;
        r_din       <= n_din;
        r_res       <= n_res;
        r_data_out  <= n_data_out;
    end

    always_comb begin
        n_state     = r_state;
        n_keyed     = r_keyed;
        n_i         = r_i;
        n_j         = r_j;
        n_n         = r_n;
        n_kidx      = r_kidx;
        n_klen_last = r_klen_last;
        n_si        = r_si;
        n_sj        = r_sj;
        n_t         = r_t;
        n_din       = r_din;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_out_ready;
        n_data_out  = r_data_out;
        mem_we      = 1'b0;
        mem_waddr   = r_n;
        mem_wdata   = r_n;
        mem_raddr   = r_n;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_REKEY: begin
                            n_n         = '0;
                            n_j         = '0;
                            n_kidx      = '0;
                            n_klen_last = klen_eff_m1;
                            n_state     = S_INIT;
                        end
                        OP_NEWMSG: begin
                            n_i = '0;
                            n_j = '0;
                        end
                        OP_DATA: begin
                            if (r_keyed) begin
                                n_i       = r_i + 8'd1;
                                mem_raddr = n_i;
                                n_din     = i_data_in;
                                n_state   = S_DAT_J;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // identity fill
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = r_n;
                n_n       = r_n + 8'd1;
                if (r_n == 8'hFF) begin
                    n_state = S_KSA_RD;
                end
            end
            // schedule step: read S[n], j += S[n] + key, read S[j], swap
            S_KSA_RD: begin
                mem_raddr = r_n;
                n_state   = S_KSA_J;
            end
            S_KSA_J: begin
                n_si      = r_rdata;
                n_j       = r_j + r_rdata + key_byte;
                mem_raddr = n_j;
                n_state   = S_KSA_WI;
            end
            S_KSA_WI: begin
                mem_we    = 1'b1;
                mem_waddr = r_n;
                mem_wdata = r_rdata;
                n_state   = S_KSA_WJ;
            end
            S_KSA_WJ: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                n_n       = r_n + 8'd1;
                n_kidx    = (r_kidx == r_klen_last) ? '0 : r_kidx + KIDX_W'(1);
                if (r_n == 8'hFF) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_keyed = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_KSA_RD;
                end
            end
            // generator step
            S_DAT_J: begin
                n_si      = r_rdata;
                n_j       = r_j + r_rdata;
                mem_raddr = n_j;
                n_state   = S_DAT_SW;
            end
            S_DAT_SW: begin
                n_sj      = r_rdata;
                n_t       = r_si + r_rdata;
                mem_we    = 1'b1;
                mem_waddr = r_i;
                mem_wdata = r_rdata;
                mem_raddr = n_t;
                n_state   = S_DAT_KS;
            end
            S_DAT_KS: begin
                mem_we    = 1'b1;
                mem_waddr = r_j;
                mem_wdata = r_si;
                n_res     = r_din ^ ks;
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_data_out  = r_din ^ ks;
                    n_state     = S_IDLE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_data_out  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // idle never disturbs the permutation
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");

    // a result only appears at the end of a generator step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DAT_KS || $past(r_state) == S_EMIT))
        else $error("result without generator step");

    // generator only runs on a keyed permutation
    a_keyed_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DAT_J) |-> r_keyed)
        else $error("data step before rekey");

    // key byte index stays within the configured length during the schedule
    a_kidx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KSA_J) |-> (r_kidx <= r_klen_last))
        else $error("key index beyond key length");
`endif

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the RC4 stream cipher: directed table, then random rounds.
`timescale 1ns / 100ps

module testbench;
    import rc4_pkg::*;

    localparam int KEY_BYTES_MAX = 32;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 8;
    // A rekey keeps the block busy without any result, so every quiet point waits longer
    // than a whole rekey before touching the registers.
    localparam int SETTLE_CYCLES = 1400;
    // Longest correct stretch without a transfer is one settle; allow several times that.
    localparam int STALL_LIMIT   = 10000;
    localparam int ROUNDS        = 8;
    localparam int ROUND_ITEMS   = 103;

    // Register indexes the package does not name, and the unused ones above the key length
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_5    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7    = 3'd7;
    // Op code with no meaning: the block must swallow it
    localparam logic [OP_W-1:0]      OP_SPARE       = 2'd3;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // One directed step: either an item transfer or a register write.
    // silent marks items whose outcome is plainly "no result at all".
    typedef struct packed {
        t_row_kind              kind;
        logic [OP_W-1:0]        op;
        logic [BYTE_W-1:0]      din;
        bit                     silent;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  wdata;
    } t_plan_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [OP_W-1:0]        i_op;
    logic [BYTE_W-1:0]      i_data_in;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [BYTE_W-1:0]      o_data_out;

    // Predictor state: our own copy of the key registers, permutation and indices
    logic [CFG_DATA_W-1:0]  key_words [4];
    logic [5:0]             key_len;
    logic [7:0]             perm [256];
    logic [7:0]             idx_i;
    logic [7:0]             idx_j;
    bit                     keyed;

    logic [BYTE_W-1:0]      expected_bytes [$];
    logic [BYTE_W-1:0]      pred_byte;
    logic [BYTE_W-1:0]      want;
    logic                   in_silent;
    int unsigned            fails = 0;
    int unsigned            quiet_cycles = 0;
    int unsigned            rdy_run = 0;
    bit                     calm = 1'b0;

    t_plan_row directed_steps [40] = '{
        // before the first rekey: data is dropped, nothing else has an effect either
        '{ROW_ITEM, OP_DATA,   8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'hFF, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_SPARE,  8'hFF, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_NEWMSG, 8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        // rekey from reset values: one zero key byte
        '{ROW_ITEM, OP_REKEY,  8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h00, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'hFF, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_SPARE,  8'h5A, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h5A, 1'b0, CFG_KEY_WORD_0, 64'h0},
        // new message: indices restart, permutation carries on from the swaps
        '{ROW_ITEM, OP_NEWMSG, 8'hFF, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h00, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'hFF, 1'b0, CFG_KEY_WORD_0, 64'h0},
        // key length of zero (upper data bits set) behaves as one byte
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_0, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_LENGTH, 64'hFFFF_FFFF_FFFF_FFC0},
        '{ROW_ITEM, OP_REKEY,  8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h00, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h81, 1'b0, CFG_KEY_WORD_0, 64'h0},
        // full 32-byte key
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_1, 64'h0123_4567_89AB_CDEF},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_2, 64'hFEDC_BA98_7654_3210},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_3, 64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_LENGTH, 64'd32},
        '{ROW_ITEM, OP_REKEY,  8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h00, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'hFF, 1'b0, CFG_KEY_WORD_0, 64'h0},
        // oversize length saturates; writes to unused indexes must change nothing
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_LENGTH, 64'd63},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_SPARE_5,    64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_SPARE_6,    64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_SPARE_7,    64'hFFFF_FFFF_FFFF_FFFF},
        '{ROW_ITEM, OP_REKEY,  8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h3C, 1'b0, CFG_KEY_WORD_0, 64'h0},
        // short three-byte key, odd length so the key wraps mid-word
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_0, 64'h0000_0000_0079_654B},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_1, 64'h0},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_2, 64'h0},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_WORD_3, 64'h0},
        '{ROW_CFG,  OP_NEWMSG, 8'h00, 1'b0, CFG_KEY_LENGTH, 64'd3},
        '{ROW_ITEM, OP_REKEY,  8'h00, 1'b1, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h50, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h6C, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h61, 1'b0, CFG_KEY_WORD_0, 64'h0},
        '{ROW_ITEM, OP_DATA,   8'h69, 1'b0, CFG_KEY_WORD_0, 64'h0}
    };

    rc4_stream_cipher #(
        .MAX_KEY_BYTES (KEY_BYTES_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_op),
        .i_data_in   (i_data_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_out  (o_data_out)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Register write as the block should see it; unused indexes fall through.
    function automatic void take_register(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] wd);
        case (idx) inside
            CFG_KEY_WORD_0, CFG_KEY_WORD_1, CFG_KEY_WORD_2, CFG_KEY_WORD_3:
                key_words[idx[1:0]] = wd;
            CFG_KEY_LENGTH:
                key_len = wd[5:0];
            default: ;
        endcase
    endfunction

    // Key schedule: identity start, key byte (n mod length) at step n.
    function automatic void key_schedule();
        int unsigned            len;
        int unsigned            m;
        int                     n;
        logic [7:0]             j;
        logic [7:0]             t;
        logic [CFG_DATA_W-1:0]  w;
        len = key_len;
        if (len == 0)
            len = 1;
        if (len > KEY_BYTES_MAX)
            len = KEY_BYTES_MAX;
        for (n = 0; n < 256; n++)
            perm[n] = 8'(n);
        j = 8'd0;
        for (n = 0; n < 256; n++) begin
            m = n % len;
            w = key_words[m >> 3];
            j = j + perm[n] + w[8*(m & 7) +: 8];
            t = perm[n];
            perm[n] = perm[j];
            perm[j] = t;
        end
        idx_i = 8'd0;
        idx_j = 8'd0;
        keyed = 1'b1;
    endfunction

    // One item through the cipher; returns 1 when a byte comes out.
    function automatic bit cipher_step(input logic [OP_W-1:0] op,
                                       input logic [BYTE_W-1:0] din,
                                       output logic [BYTE_W-1:0] dout);
        logic [7:0] si;
        logic [7:0] sj;
        logic [7:0] ks_at;
        bit         made;
        made = 1'b0;
        dout = '0;
        case (op)
            OP_REKEY:
                key_schedule();
            OP_NEWMSG: begin
                idx_i = 8'd0;
                idx_j = 8'd0;
            end
            OP_DATA: begin
                if (keyed) begin
                    idx_i = idx_i + 8'd1;
                    idx_j = idx_j + perm[idx_i];
                    si = perm[idx_i];
                    sj = perm[idx_j];
                    perm[idx_i] = sj;
                    perm[idx_j] = si;
                    ks_at = si + sj;
                    dout = din ^ perm[ks_at];
                    made = 1'b1;
                end
            end
            default: ;
        endcase
        return made;
    endfunction

    // ------------------------------------------------------------------
    // Monitor: every channel sampled at the clock edge, in one process,
    // so predictions and checks never race each other.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                take_register(i_cfg_index, i_cfg_data);
            // silent rows carry their own typed expectation: no byte at all
            if (i_in_valid && o_in_ready) begin
                if (cipher_step(i_op, i_data_in, pred_byte) && !in_silent)
                    expected_bytes.push_back(pred_byte);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: data_out expected none, got %02h", $time, o_data_out);
                    fails++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_data_out !== want) begin
                        $display("%0t: data_out expected %02h, got %02h",
                                 $time, want, o_data_out);
                        fails++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready) ||
            (o_out_valid && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random ready runs and stall bursts, always ready once calm
    always @(posedge i_clk) begin
        if (calm) begin
            i_out_ready <= 1'b1;
        end else if (rdy_run != 0) begin
            rdy_run <= rdy_run - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            i_out_ready <= 1'b0;
            rdy_run     <= $urandom_range(0, 11);
        end else begin
            i_out_ready <= 1'b1;
            rdy_run     <= $urandom_range(0, 30);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    // Present one item and hold it until the transfer. Valid is left high so that
    // back-to-back items never drop it within one step.
    task automatic feed(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] din,
                        input bit silent);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_data_in  <= din;
        in_silent  <= silent;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] wd);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= wd;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic hold_off(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Sender pauses until every predicted byte has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bytes.size() != 0);
    endtask

    // Drained and then long enough for a trailing rekey to finish
    task automatic settle_block();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int                     k;
        int                     w;
        int                     rnd;
        int unsigned            r;
        bit                     cfg_open;
        logic [OP_W-1:0]        op;
        logic [CFG_DATA_W-1:0]  wd;

        for (k = 0; k < 4; k++)
            key_words[k] = '0;
        key_len  = 6'd1;
        idx_i    = 8'd0;
        idx_j    = 8'd0;
        keyed    = 1'b0;
        cfg_open = 1'b0;

        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_KEY_WORD_0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_op        <= OP_NEWMSG;
        i_data_in   <= '0;
        i_out_ready <= 1'b0;
        in_silent   <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; register writes only once the block has gone quiet
        for (k = 0; k < $size(directed_steps); k++) begin
            if (directed_steps[k].kind == ROW_CFG) begin
                if (!cfg_open) begin
                    settle_block();
                    cfg_open = 1'b1;
                end
                write_register(directed_steps[k].idx, directed_steps[k].wdata);
            end else begin
                if (cfg_open) begin
                    i_cfg_valid <= 1'b0;
                    cfg_open = 1'b0;
                end
                feed(directed_steps[k].op, directed_steps[k].din, directed_steps[k].silent);
                if ($urandom_range(0, 2) == 0)
                    hold_off($urandom_range(1, 12));
            end
        end

        // Random rounds: fresh key, a rekey, then a long well-formed stream with
        // the odd new message, rekey or dropped op mixed in. Last round runs flat out.
        for (rnd = 0; rnd < ROUNDS; rnd++) begin
            calm = (rnd == ROUNDS - 1);
            settle_block();
            for (w = 0; w < 4; w++) begin
                if ($urandom_range(0, 3) != 0) begin
                    case ($urandom_range(0, 7))
                        0:       wd = '0;
                        1:       wd = '1;
                        default: wd = {$urandom, $urandom};
                    endcase
                    write_register(CFG_KEY_WORD_0 + CFG_IDX_W'(w), wd);
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_register(CFG_SPARE_5 + CFG_IDX_W'($urandom_range(0, 2)),
                               {$urandom, $urandom});
            // length register: extremes often, junk in the unused upper bits
            wd = {$urandom, $urandom};
            case ($urandom_range(0, 5))
                0:       wd[5:0] = 6'd0;
                1:       wd[5:0] = 6'd1;
                2:       wd[5:0] = 6'(KEY_BYTES_MAX);
                3:       wd[5:0] = 6'($urandom_range(KEY_BYTES_MAX + 1, 63));
                default: wd[5:0] = 6'($urandom_range(1, KEY_BYTES_MAX));
            endcase
            write_register(CFG_KEY_LENGTH, wd);
            i_cfg_valid <= 1'b0;

            feed(OP_REKEY, 8'($urandom_range(0, 255)), 1'b0);
            for (k = 0; k < ROUND_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = OP_REKEY;
                else if (r < 9)
                    op = OP_NEWMSG;
                else if (r < 13)
                    op = OP_SPARE;
                else
                    op = OP_DATA;
                if (!calm && $urandom_range(0, 39) == 0)
                    drain_results();
                else if (!calm && $urandom_range(0, 3) == 0)
                    hold_off($urandom_range(1, 12));
                feed(op, 8'($urandom_range(0, 255)), 1'b0);
            end
        end

        settle_block();
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
